// ----- rtl/reader_writer_lock_arbiter_assert.svh -----
// Assertion macros shared by the lock arbiter RTL.
`ifndef READER_WRITER_LOCK_ARBITER_ASSERT_SVH
`define READER_WRITER_LOCK_ARBITER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RWLA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rwla assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RWLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwla assertion failed");

`endif

// ----- rtl/rwla_pkg.sv -----
package rwla_pkg;

  localparam int MODE_W   = 3;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int PREF_W   = 2;
  localparam int RCNT_W   = 5;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [TID_W-1:0]    tid_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PREF_W-1:0]   pref_t;

  localparam mode_t MODE_ENQ_RD   = 3'd0;
  localparam mode_t MODE_ENQ_WR   = 3'd1;
  localparam mode_t MODE_TRY_RD   = 3'd2;
  localparam mode_t MODE_TRY_WR   = 3'd3;
  localparam mode_t MODE_UNLOCK   = 3'd4;
  localparam mode_t MODE_INIT     = 3'd5;
  localparam mode_t MODE_DESTROY  = 3'd6;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_BLOCKED    = 3'd2;
  localparam status_t ST_NOT_HOLDER = 3'd3;
  localparam status_t ST_UNLOCKED   = 3'd4;

  localparam pref_t PREF_READER  = 2'd0;
  localparam pref_t PREF_WRITER  = 2'd1;
  localparam pref_t PREF_ARRIVAL = 2'd2;
  localparam pref_t PREF_UNUSED  = 2'd3;
  localparam pref_t PREF_RESET   = PREF_ARRIVAL;

  // Queue indexes into the pointer arrays.
  localparam int Q_READ   = 0;
  localparam int Q_WRITE  = 1;
  localparam int Q_ARRIVE = 2;
  localparam int NUM_Q    = 3;

endpackage

// ----- rtl/rwla_if.sv -----
interface rwla_req_if;
  logic                 valid;
  logic                 ready;
  rwla_pkg::mode_t      mode;
  rwla_pkg::tid_t       thread_id;

  modport source (output valid, output mode, output thread_id, input ready);
  modport sink   (input valid, input mode, input thread_id, output ready);
endinterface

interface rwla_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  rwla_pkg::status_t           status;
  logic                        writer_held;
  logic [rwla_pkg::RCNT_W-1:0] reader_count;
  logic                        readers_waiting;
  logic                        writers_waiting;
  logic                        destroyed;

  modport source (output valid, output granted, output status, output writer_held,
                  output reader_count, output readers_waiting, output writers_waiting,
                  output destroyed, input ready);
  modport sink   (input valid, input granted, input status, input writer_held,
                  input reader_count, input readers_waiting, input writers_waiting,
                  input destroyed, output ready);
endinterface

// ----- rtl/rwla_ram.sv -----
module rwla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/reader_writer_lock_arbiter.sv -----
// Reader-writer lock arbiter.
// Requests arrive on req_i (mode, thread_id) and each produces exactly one
// response beat on rsp_o with the grant flag, a status code and a snapshot
// of the lock after the request. A beat is taken when valid and ready are
// both high. The preference register is written through cfg_we_i/cfg_wdata_i;
// the user must do so only while the block is idle, which the block itself
// does not enforce; it resets to arrival order. A request is taken in S_IDLE,
// decided in the next cycle in S_EXEC and its response loaded into the output
// register from S_FIN, so a new request is taken only after the last one has
// left S_FIN. An unlock that releases a reader walks the active-reader memory
// through its single read port: S_LREAD reads each entry and S_LCMP compares
// it with the thread id; on a match that is not the last entry, S_LMOVE moves
// the last entry into the freed slot. The response sits in an output
// register; the next request is accepted while it waits, and processing
// stalls only when a new response is ready and the old one has not yet
// been taken. Reset empties all queues, drops all holders, clears the
// destroyed flag; the queue memories are not cleared.
`include "reader_writer_lock_arbiter_assert.svh"

module reader_writer_lock_arbiter #(
  parameter int MAX_THREADS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  rwla_pkg::pref_t         cfg_wdata_i,
  rwla_req_if.sink                req_i,
  rwla_rsp_if.source              rsp_o
);

  localparam int AW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_THREADS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_THREADS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_LREAD = 3'd2;
  localparam logic [2:0] S_LCMP  = 3'd3;
  localparam logic [2:0] S_LMOVE = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_q, state_d;
  rwla_pkg::pref_t   pref_q;
  rwla_pkg::mode_t   mode_q, mode_d;
  rwla_pkg::tid_t    tid_q, tid_d;
  logic [AW-1:0]     head_q [rwla_pkg::NUM_Q];
  logic [AW-1:0]     head_d [rwla_pkg::NUM_Q];
  logic [CW-1:0]     cnt_q  [rwla_pkg::NUM_Q];
  logic [CW-1:0]     cnt_d  [rwla_pkg::NUM_Q];
  logic [AW-1:0]     slot   [rwla_pkg::NUM_Q];
  logic [AW-1:0]     head_nx [rwla_pkg::NUM_Q];
  logic [SW-1:0]     slot_sum [rwla_pkg::NUM_Q];
  logic [CW-1:0]     act_q, act_d;
  logic              wrv_q, wrv_d;
  rwla_pkg::tid_t    wrt_q, wrt_d;
  logic              dst_q, dst_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              res_g_q, res_g_d;
  rwla_pkg::status_t res_s_q, res_s_d;

  logic                    rsp_valid_q, rsp_valid_d;
  logic                    rsp_load;
  logic                    rsp_g_q;
  rwla_pkg::status_t       rsp_s_q;
  logic                    rsp_wh_q;
  logic [rwla_pkg::RCNT_W-1:0] rsp_rc_q;
  logic                    rsp_rw_q, rsp_ww_q, rsp_ds_q;
  logic [31:0]             act_ext;

  logic              r_we, w_we, a_we, l_we;
  logic [AW-1:0]     l_waddr, l_raddr, act_last;
  rwla_pkg::tid_t    l_wdata;
  rwla_pkg::tid_t    r_rdata, w_rdata, a_rdata, l_rdata;

  rwla_pkg::pref_t   pref_eff;
  logic              hit_r, hit_w, hit_a, rd_ok, wr_ok;

  rwla_ram #(.WIDTH(rwla_pkg::TID_W), .DEPTH(MAX_THREADS)) u_rd_fifo (
    .clk_i(clk_i), .we_i(r_we), .waddr_i(slot[rwla_pkg::Q_READ]), .wdata_i(tid_q),
    .raddr_i(head_q[rwla_pkg::Q_READ]), .rdata_o(r_rdata)
  );

  rwla_ram #(.WIDTH(rwla_pkg::TID_W), .DEPTH(MAX_THREADS)) u_wr_fifo (
    .clk_i(clk_i), .we_i(w_we), .waddr_i(slot[rwla_pkg::Q_WRITE]), .wdata_i(tid_q),
    .raddr_i(head_q[rwla_pkg::Q_WRITE]), .rdata_o(w_rdata)
  );

  rwla_ram #(.WIDTH(rwla_pkg::TID_W), .DEPTH(MAX_THREADS)) u_arr_fifo (
    .clk_i(clk_i), .we_i(a_we), .waddr_i(slot[rwla_pkg::Q_ARRIVE]), .wdata_i(tid_q),
    .raddr_i(head_q[rwla_pkg::Q_ARRIVE]), .rdata_o(a_rdata)
  );

  rwla_ram #(.WIDTH(rwla_pkg::TID_W), .DEPTH(MAX_THREADS)) u_act_list (
    .clk_i(clk_i), .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  // Tail slot and wrapped next head for each queue.
  always_comb begin
    for (int q = 0; q < rwla_pkg::NUM_Q; q++) begin
      slot_sum[q] = SW'(head_q[q]) + SW'(cnt_q[q]);
      if (slot_sum[q] >= SW'(MAX_THREADS)) begin
        slot_sum[q] = slot_sum[q] - SW'(MAX_THREADS);
      end
      slot[q]    = slot_sum[q][AW-1:0];
      head_nx[q] = (head_q[q] == LAST_SLOT) ? '0 : head_q[q] + AW'(1);
    end
  end

  assign pref_eff = (pref_q == rwla_pkg::PREF_UNUSED) ? rwla_pkg::PREF_ARRIVAL : pref_q;

  // The queue heads were read out when the request was accepted.
  assign hit_r = (cnt_q[rwla_pkg::Q_READ]   != '0) && (r_rdata == tid_q);
  assign hit_w = (cnt_q[rwla_pkg::Q_WRITE]  != '0) && (w_rdata == tid_q);
  assign hit_a = (cnt_q[rwla_pkg::Q_ARRIVE] != '0) && (a_rdata == tid_q);

  assign rd_ok = !(pref_eff == rwla_pkg::PREF_WRITER && cnt_q[rwla_pkg::Q_WRITE] != '0)
                 && !wrv_q
                 && ((pref_eff == rwla_pkg::PREF_ARRIVAL) ? hit_a : hit_r)
                 && hit_r && (cnt_q[rwla_pkg::Q_ARRIVE] != '0);

  assign wr_ok = !(pref_eff == rwla_pkg::PREF_READER && cnt_q[rwla_pkg::Q_READ] != '0)
                 && !wrv_q && (act_q == '0)
                 && ((pref_eff == rwla_pkg::PREF_ARRIVAL) ? hit_a : hit_w)
                 && hit_w && (cnt_q[rwla_pkg::Q_ARRIVE] != '0);

  assign act_last = AW'(act_q - CW'(1));
  assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    tid_d   = tid_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    wrv_d   = wrv_q;
    wrt_d   = wrt_q;
    dst_d   = dst_q;
    idx_d   = idx_q;
    res_g_d = res_g_q;
    res_s_d = res_s_q;
    r_we    = 1'b0;
    w_we    = 1'b0;
    a_we    = 1'b0;
    l_we    = 1'b0;
    l_waddr = act_q[AW-1:0];
    l_wdata = tid_q;
    l_raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d  = req_i.mode;
          tid_d   = req_i.thread_id;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_g_d = 1'b0;
        res_s_d = rwla_pkg::ST_OK;
        state_d = S_FIN;
        case (mode_q)
          rwla_pkg::MODE_ENQ_RD: begin
            if (cnt_q[rwla_pkg::Q_READ] == MAXC || cnt_q[rwla_pkg::Q_ARRIVE] == MAXC) begin
              res_s_d = rwla_pkg::ST_FULL;
            end else begin
              r_we = 1'b1;
              a_we = 1'b1;
              cnt_d[rwla_pkg::Q_READ]   = cnt_q[rwla_pkg::Q_READ] + CW'(1);
              cnt_d[rwla_pkg::Q_ARRIVE] = cnt_q[rwla_pkg::Q_ARRIVE] + CW'(1);
            end
          end
          rwla_pkg::MODE_ENQ_WR: begin
            if (cnt_q[rwla_pkg::Q_WRITE] == MAXC || cnt_q[rwla_pkg::Q_ARRIVE] == MAXC) begin
              res_s_d = rwla_pkg::ST_FULL;
            end else begin
              w_we = 1'b1;
              a_we = 1'b1;
              cnt_d[rwla_pkg::Q_WRITE]  = cnt_q[rwla_pkg::Q_WRITE] + CW'(1);
              cnt_d[rwla_pkg::Q_ARRIVE] = cnt_q[rwla_pkg::Q_ARRIVE] + CW'(1);
            end
          end
          rwla_pkg::MODE_TRY_RD: begin
            if (!rd_ok) begin
              res_s_d = rwla_pkg::ST_BLOCKED;
            end else if (act_q == MAXC) begin
              res_s_d = rwla_pkg::ST_FULL;
            end else begin
              l_we    = 1'b1;
              act_d   = act_q + CW'(1);
              res_g_d = 1'b1;
              head_d[rwla_pkg::Q_READ]   = head_nx[rwla_pkg::Q_READ];
              head_d[rwla_pkg::Q_ARRIVE] = head_nx[rwla_pkg::Q_ARRIVE];
              cnt_d[rwla_pkg::Q_READ]    = cnt_q[rwla_pkg::Q_READ] - CW'(1);
              cnt_d[rwla_pkg::Q_ARRIVE]  = cnt_q[rwla_pkg::Q_ARRIVE] - CW'(1);
            end
          end
          rwla_pkg::MODE_TRY_WR: begin
            if (!wr_ok) begin
              res_s_d = rwla_pkg::ST_BLOCKED;
            end else begin
              wrv_d   = 1'b1;
              wrt_d   = tid_q;
              res_g_d = 1'b1;
              head_d[rwla_pkg::Q_WRITE]  = head_nx[rwla_pkg::Q_WRITE];
              head_d[rwla_pkg::Q_ARRIVE] = head_nx[rwla_pkg::Q_ARRIVE];
              cnt_d[rwla_pkg::Q_WRITE]   = cnt_q[rwla_pkg::Q_WRITE] - CW'(1);
              cnt_d[rwla_pkg::Q_ARRIVE]  = cnt_q[rwla_pkg::Q_ARRIVE] - CW'(1);
            end
          end
          rwla_pkg::MODE_UNLOCK: begin
            if (wrv_q) begin
              if (wrt_q != tid_q) begin
                res_s_d = rwla_pkg::ST_NOT_HOLDER;
              end else begin
                wrv_d = 1'b0;
                wrt_d = '0;
              end
            end else if (act_q == '0) begin
              res_s_d = rwla_pkg::ST_UNLOCKED;
            end else begin
              idx_d   = '0;
              state_d = S_LREAD;
            end
          end
          rwla_pkg::MODE_INIT:    dst_d = 1'b0;
          rwla_pkg::MODE_DESTROY: dst_d = 1'b1;
          default: ;
        endcase
      end
      S_LREAD: begin
        l_raddr = idx_q;
        state_d = S_LCMP;
      end
      S_LCMP: begin
        // Fetch the last entry now so a match can be backfilled next cycle.
        l_raddr = act_last;
        if (l_rdata == tid_q) begin
          if (idx_q == act_last) begin
            act_d   = act_q - CW'(1);
            state_d = S_FIN;
          end else begin
            state_d = S_LMOVE;
          end
        end else if (idx_q == act_last) begin
          res_s_d = rwla_pkg::ST_NOT_HOLDER;
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_LREAD;
        end
      end
      S_LMOVE: begin
        l_we    = 1'b1;
        l_waddr = idx_q;
        l_wdata = l_rdata;
        act_d   = act_q - CW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_d = rsp_load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);
  assign act_ext     = 32'(act_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pref_q      <= rwla_pkg::PREF_RESET;
      for (int q = 0; q < rwla_pkg::NUM_Q; q++) begin
        head_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
      act_q       <= '0;
      wrv_q       <= 1'b0;
      wrt_q       <= '0;
      dst_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        pref_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      act_q       <= act_d;
      wrv_q       <= wrv_d;
      wrt_q       <= wrt_d;
      dst_q       <= dst_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    tid_q   <= tid_d;
    idx_q   <= idx_d;
    res_g_q <= res_g_d;
    res_s_q <= res_s_d;
    if (rsp_load) begin
      rsp_g_q  <= res_g_q;
      rsp_s_q  <= res_s_q;
      rsp_wh_q <= wrv_q;
      rsp_rc_q <= act_ext[rwla_pkg::RCNT_W-1:0];
      rsp_rw_q <= (cnt_q[rwla_pkg::Q_READ] != '0);
      rsp_ww_q <= (cnt_q[rwla_pkg::Q_WRITE] != '0);
      rsp_ds_q <= dst_q;
    end
  end

  assign req_i.ready           = (state_q == S_IDLE);
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.granted         = rsp_g_q;
  assign rsp_o.status          = rsp_s_q;
  assign rsp_o.writer_held     = rsp_wh_q;
  assign rsp_o.reader_count    = rsp_rc_q;
  assign rsp_o.readers_waiting = rsp_rw_q;
  assign rsp_o.writers_waiting = rsp_ww_q;
  assign rsp_o.destroyed       = rsp_ds_q;

  // Every enqueue and every grant touches the arrival queue and one other.
  `RWLA_ASSERT_IMPL(a_arrival_sum, 1'b1,
    (({1'b0, cnt_q[rwla_pkg::Q_READ]} + {1'b0, cnt_q[rwla_pkg::Q_WRITE]})
      == {1'b0, cnt_q[rwla_pkg::Q_ARRIVE]}))
  `RWLA_ASSERT_IMPL(a_excl_holder, wrv_q, act_q == '0)
  `RWLA_ASSERT_IMPL(a_scan_in_range, (state_q == S_LCMP || state_q == S_LMOVE),
    (({1'b0, idx_q} < {1'b0, act_q}) && !wrv_q))
  `RWLA_ASSERT_NEXT(a_accept_starts, req_i.valid && req_i.ready, state_q == S_EXEC)

endmodule
